@@ sv/time_string_to_seconds_unit_macros.svh @@
// Assertion macros for the time string parser.
// Used at the end of time_string_to_seconds_unit; expects clk and arst_n in scope.
`ifndef TIME_STRING_TO_SECONDS_UNIT_MACROS_SVH
`define TIME_STRING_TO_SECONDS_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tss: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tss: next-cycle check failed");

`endif

@@ sv/tss_pkg.sv @@
// Package for the time string parser: widths, character codes, status codes,
// fraction digit weights and the field fold. No dependencies.
package tss_pkg;

	localparam int CH_W      = 8;
	localparam int MICROS_W  = 52;
	localparam int STATUS_W  = 2;
	localparam int WHOLE_W   = 20;
	localparam int FRAC_W    = 20;
	localparam int OUT_TDATA_W = ((MICROS_W + STATUS_W + 7) / 8) * 8;

	localparam int DEF_MAX_FIELDS  = 3;
	localparam int DEF_FRAC_DIGITS = 6;

	localparam logic [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(999999);

	typedef logic [CH_W-1:0]     ch_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BAD    = 2'd1;
	localparam status_t ST_FIELDS = 2'd2;

	localparam ch_t CH_NUL   = 8'h00;
	localparam ch_t CH_TAB   = 8'h09;
	localparam ch_t CH_CR    = 8'h0D;
	localparam ch_t CH_SPACE = 8'h20;
	localparam ch_t CH_POINT = 8'h2E;
	localparam ch_t CH_ZERO  = 8'h30;
	localparam ch_t CH_NINE  = 8'h39;
	localparam ch_t CH_COLON = 8'h3A;

	// weight in us of fraction digit k, k = 0 first after the point
	function automatic logic [16:0] frac_weight(input logic [2:0] k);
		logic [16:0] w;
		case (k)
			3'd0:    w = 17'd100000;
			3'd1:    w = 17'd10000;
			3'd2:    w = 17'd1000;
			3'd3:    w = 17'd100;
			3'd4:    w = 17'd10;
			3'd5:    w = 17'd1;
			default: w = 17'd0;
		endcase
		return w;
	endfunction

	// total*60 + whole*1e6 + frac, modulo 2^52
	function automatic logic [MICROS_W-1:0] tss_fold(
		input logic [MICROS_W-1:0] run,
		input logic [WHOLE_W-1:0]  whole,
		input logic [FRAC_W-1:0]   frac
	);
		logic [MICROS_W-1:0] run_x60;
		logic [MICROS_W-1:0] whole_us;
		run_x60  = {run[MICROS_W-7:0], 6'b0} - {run[MICROS_W-3:0], 2'b0};
		whole_us = MICROS_W'(whole) * MICROS_W'(1000000);
		return run_x60 + whole_us + MICROS_W'(frac);
	endfunction

endpackage

@@ sv/time_string_to_seconds_unit.sv @@
// Time string parser top level: characters in, durations in microseconds out.
// Depends on tss_pkg and time_string_to_seconds_unit_macros.svh.
`include "time_string_to_seconds_unit_macros.svh"

// Parses hh:mm:ss.s strings arriving one character per item and gives one
// result per string, when a NUL, space or tab ends it: the duration in
// microseconds and a status (0 valid, 1 bad character or second point,
// 2 too many fields; value 0 unless valid). Leading whitespace is skipped.
// Throughput is one character per clock while the result side keeps up;
// a result left waiting holds the input register, which then stalls the input.
// A character accepted into the input register is decoded out of it, and the result
// of the character that ends a string is registered in the result register and
// offered from it. The fold of a field (total*60 + field) is done in the same
// single pass as the character decode.
module time_string_to_seconds_unit #(
	parameter int MAX_FIELDS  = tss_pkg::DEF_MAX_FIELDS,
	parameter int FRAC_DIGITS = tss_pkg::DEF_FRAC_DIGITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tss_pkg::CH_W-1:0]        s_axis_tdata,  // [7:0] ch
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tss_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [51:0] micros, [53:52] status
);
	import tss_pkg::*;

	localparam int FC_W = $clog2(FRAC_DIGITS + 1);

	// input stage
	logic valid_s1;
	ch_t  ch_s1;

	// parser state
	logic                in_tok_q;
	logic [WHOLE_W-1:0]  whole_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [FC_W-1:0]     frac_cnt_q;
	logic                after_pt_q;
	logic                pt_seen_q;
	logic [1:0]          sep_q;
	logic [MICROS_W-1:0] run_q;
	logic                bad_q;

	// result register
	logic                out_valid_q;
	logic [MICROS_W-1:0] micros_q;
	status_t             status_q;

	logic                advance, skip, is_term, is_digit, fields_over;
	logic [3:0]          digit;
	logic [MICROS_W-1:0] fold_val;
	logic [23:0]         whole_x10;
	logic [FRAC_W-1:0]   frac_add;

	always_comb begin
		advance     = valid_s1 && (!out_valid_q || m_axis_tready);
		skip        = !in_tok_q && (ch_s1 inside {CH_SPACE, [CH_TAB:CH_CR]});
		is_term     = ch_s1 inside {CH_NUL, CH_SPACE, CH_TAB};
		is_digit    = ch_s1 inside {[CH_ZERO:CH_NINE]};
		digit       = ch_s1[3:0];
		fields_over = sep_q >= 2'(MAX_FIELDS);
		fold_val    = tss_fold(run_q, whole_q, frac_q);
		whole_x10   = 24'({whole_q, 3'b0}) + 24'({whole_q, 1'b0}) + 24'(digit);
		frac_add    = FRAC_W'(digit) * FRAC_W'(frac_weight(3'(frac_cnt_q)));
	end

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tok_q   <= 1'b0;
			whole_q    <= '0;
			frac_q     <= '0;
			frac_cnt_q <= '0;
			after_pt_q <= 1'b0;
			pt_seen_q  <= 1'b0;
			sep_q      <= '0;
			run_q      <= '0;
			bad_q      <= 1'b0;
		end else if (advance && !skip) begin
			in_tok_q <= 1'b1;
			if (is_term) begin
				in_tok_q   <= 1'b0;
				whole_q    <= '0;
				frac_q     <= '0;
				frac_cnt_q <= '0;
				after_pt_q <= 1'b0;
				pt_seen_q  <= 1'b0;
				sep_q      <= '0;
				run_q      <= '0;
				bad_q      <= 1'b0;
			end else if (ch_s1 == CH_COLON) begin
				if (!bad_q && !fields_over) begin
					run_q <= fold_val;
				end
				if (sep_q != 2'd3) begin
					sep_q <= sep_q + 2'd1;
				end
				whole_q    <= '0;
				frac_q     <= '0;
				frac_cnt_q <= '0;
				after_pt_q <= 1'b0;
			end else if (ch_s1 == CH_POINT) begin
				if (pt_seen_q) begin
					bad_q <= 1'b1;
				end
				pt_seen_q  <= 1'b1;
				after_pt_q <= 1'b1;
			end else if (is_digit) begin
				if (after_pt_q) begin
					if (frac_cnt_q < FC_W'(FRAC_DIGITS)) begin
						frac_q     <= frac_q + frac_add;
						frac_cnt_q <= frac_cnt_q + FC_W'(1);
					end
				end else begin
					whole_q <= (whole_x10 > 24'(WHOLE_MAX)) ? WHOLE_MAX : whole_x10[WHOLE_W-1:0];
				end
			end else begin
				bad_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && !skip && is_term) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !skip && is_term) begin
			if (bad_q) begin
				micros_q <= '0;
				status_q <= ST_BAD;
			end else if (fields_over) begin
				micros_q <= '0;
				status_q <= ST_FIELDS;
			end else begin
				micros_q <= fold_val;
				status_q <= ST_OK;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - MICROS_W - STATUS_W){1'b0}}, status_q, micros_q};

	`TSS_ASSERT_NOW(a_err_zero, out_valid_q && status_q != ST_OK, micros_q == '0)
	`TSS_ASSERT_NOW(a_status_code, out_valid_q, status_q <= ST_FIELDS)
	`TSS_ASSERT_NEXT(a_term_clears, advance && !skip && is_term, !in_tok_q && !bad_q && sep_q == 2'd0)
	`TSS_ASSERT_NOW(a_bad_in_token, bad_q || pt_seen_q, in_tok_q)

endmodule

@@ test/tb_time_string_to_seconds_unit.sv @@
// Testbench for time_string_to_seconds_unit: streams characters, takes each duration and
// status typed in or from a behavioural parser; compares each result item field by field.
// Depends on tss_pkg and the block under test.
module tb_time_string_to_seconds_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tss_pkg::*;

	localparam ch_t CH_LF = 8'h0A;
	localparam ch_t CH_VT = 8'h0B;
	localparam ch_t CH_FF = 8'h0C;

	localparam int N_CHARS  = 1750;
	localparam int HOLD_AT  = 700;   // receiver stalls for a long stretch here
	localparam int HOLD_LEN = 300;
	localparam int QUIET_AT = 1550;  // no idling from here on

	localparam ch_t LEAD_WS [6] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF};
	localparam int unsigned FRAC_STEP [6] = '{100000, 10000, 1000, 100, 10, 1};

	typedef struct packed {
		logic [MICROS_W-1:0] us;
		status_t             st;
	} duration_t;

	typedef struct packed {
		ch_t       c;
		logic      typed;
		duration_t res;
	} row_t;

	typedef struct packed {
		logic                in_tok;
		logic [WHOLE_W-1:0]  whole;
		logic [FRAC_W-1:0]   frac;
		logic [2:0]          nfrac;
		logic                past_pt;
		logic                pt_any;
		logic [1:0]          colons;
		logic [MICROS_W-1:0] total;
		logic                bad;
	} parse_state_t;

	// opening rows: expected values typed in where obvious, the rest predicted
	localparam int N_OPEN = 32;
	localparam row_t OPENING_ROWS [N_OPEN] = '{
		'{CH_NUL,   1'b1, '{52'd0, ST_OK}},
		'{CH_SPACE, 1'b0, '0},
		'{CH_TAB,   1'b0, '0},
		'{CH_CR,    1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{CH_VT,    1'b0, '0},
		'{CH_FF,    1'b0, '0},
		'{"1",      1'b0, '0},
		'{CH_COLON, 1'b0, '0},
		'{"2",      1'b0, '0},
		'{CH_COLON, 1'b0, '0},
		'{"3",      1'b0, '0},
		'{CH_POINT, 1'b0, '0},
		'{"5",      1'b0, '0},
		'{CH_SPACE, 1'b1, '{52'd3723500000, ST_OK}},
		'{8'hFF,    1'b0, '0},
		'{CH_TAB,   1'b1, '{52'd0, ST_BAD}},
		'{CH_COLON, 1'b0, '0},
		'{CH_COLON, 1'b0, '0},
		'{CH_COLON, 1'b0, '0},
		'{CH_NUL,   1'b1, '{52'd0, ST_FIELDS}},
		'{"9",      1'b0, '0},
		'{"9",      1'b0, '0},
		'{"9",      1'b0, '0},
		'{"9",      1'b0, '0},
		'{"9",      1'b0, '0},
		'{"9",      1'b0, '0},
		'{"9",      1'b0, '0},
		'{CH_NUL,   1'b1, '{52'd999999000000, ST_OK}},
		'{CH_POINT, 1'b0, '0},
		'{CH_POINT, 1'b0, '0},
		'{CH_NUL,   1'b1, '{52'd0, ST_BAD}}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [CH_W-1:0]        s_axis_tdata;   // [7:0] ch
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [51:0] micros, [53:52] status

	parse_state_t ps;
	duration_t    durations_due [$];
	ch_t          line_q [$];
	int           chars_sent = 0;
	int           mismatches = 0;
	bit           idle_on = 1'b1;
	bit           hold_req = 1'b0;

	time_string_to_seconds_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void parse_reset();
		ps = '0;
	endfunction

	function automatic void fold_field();
		ps.total = ps.total * 52'd60 + MICROS_W'(ps.whole) * 52'd1000000 + MICROS_W'(ps.frac);
	endfunction

	// one character into the parser; returns 1 when it closes a string
	function automatic bit parse_char(input ch_t c, output duration_t res);
		int unsigned d;
		int unsigned w;
		res = '0;
		if (!ps.in_tok && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
			return 1'b0;
		ps.in_tok = 1'b1;
		if (c == CH_NUL || c == CH_SPACE || c == CH_TAB) begin
			if (ps.bad) begin
				res.st = ST_BAD;
			end else if (ps.colons >= DEF_MAX_FIELDS) begin
				res.st = ST_FIELDS;
			end else begin
				fold_field();
				res.us = ps.total;
				res.st = ST_OK;
			end
			parse_reset();
			return 1'b1;
		end
		if (c == CH_COLON) begin
			// colons past the field limit are not folded
			if (!ps.bad && ps.colons < DEF_MAX_FIELDS)
				fold_field();
			if (ps.colons != 2'd3)
				ps.colons++;
			ps.whole = '0;
			ps.frac = '0;
			ps.nfrac = '0;
			ps.past_pt = 1'b0;
		end else if (c == CH_POINT) begin
			if (ps.pt_any)
				ps.bad = 1'b1;
			ps.pt_any = 1'b1;
			ps.past_pt = 1'b1;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			d = int'(c - CH_ZERO);
			if (ps.past_pt) begin
				if (ps.nfrac < DEF_FRAC_DIGITS) begin
					ps.frac = ps.frac + FRAC_W'(d * FRAC_STEP[ps.nfrac]);
					ps.nfrac++;
				end
			end else begin
				w = int'(ps.whole) * 10 + d;
				ps.whole = (w > int'(WHOLE_MAX)) ? WHOLE_MAX : w[WHOLE_W-1:0];
			end
		end else begin
			ps.bad = 1'b1;
		end
		return 1'b0;
	endfunction

	// entered and left at a falling edge
	task automatic send_char(input ch_t c, input bit typed, input duration_t typed_res);
		duration_t got;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		if (parse_char(c, got))
			durations_due.push_back(typed ? typed_res : got);
		chars_sent++;
		if (chars_sent == HOLD_AT)
			hold_req = 1'b1;
		if (chars_sent == QUIET_AT)
			idle_on = 1'b0;
		@(negedge clk);
	endtask

	// mostly well-formed hh:mm:ss.s text with random content, some noise
	task automatic build_line();
		int nfields;
		int nd;
		bit pt_used;
		line_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) line_q.push_back(ch_t'($urandom_range(0, 255)));
			line_q.push_back(CH_NUL);
			return;
		end
		repeat ($urandom_range(0, 2)) line_q.push_back(LEAD_WS[$urandom_range(0, 5)]);
		nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
		pt_used = 1'b0;
		for (int i = 0; i < nfields; i++) begin
			if (i != 0)
				line_q.push_back(CH_COLON);
			nd = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 2);
			repeat (nd) line_q.push_back(CH_ZERO + ch_t'($urandom_range(0, 9)));
			if ((!pt_used || $urandom_range(0, 19) == 0) && $urandom_range(0, 2) == 0) begin
				pt_used = 1'b1;
				line_q.push_back(CH_POINT);
				repeat ($urandom_range(0, 8)) line_q.push_back(CH_ZERO + ch_t'($urandom_range(0, 9)));
			end
		end
		if ($urandom_range(0, 6) == 0)
			line_q.insert($urandom_range(0, line_q.size()), ch_t'($urandom_range(0, 255)));
		case ($urandom_range(0, 2))
			0:       line_q.push_back(CH_NUL);
			1:       line_q.push_back(CH_SPACE);
			default: line_q.push_back(CH_TAB);
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		parse_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_OPEN; i++)
			send_char(OPENING_ROWS[i].c, OPENING_ROWS[i].typed, OPENING_ROWS[i].res);
		while (chars_sent < N_CHARS) begin
			build_line();
			foreach (line_q[i])
				send_char(line_q[i], 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		while (durations_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (durations_due.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: random stalls, one long hold, steady at the end
	initial begin
		int burst;
		burst = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end else if (burst > 0) begin
				burst--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		duration_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (durations_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: micros %0d status %0d",
						m_axis_tdata[MICROS_W-1:0], m_axis_tdata[MICROS_W+:STATUS_W]);
			end else begin
				want = durations_due.pop_front();
				if (m_axis_tdata[MICROS_W-1:0] !== want.us ||
						m_axis_tdata[MICROS_W+:STATUS_W] !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: micros %0d status %0d, expected %0d status %0d",
							m_axis_tdata[MICROS_W-1:0], m_axis_tdata[MICROS_W+:STATUS_W],
							want.us, want.st);
				end
			end
		end
	end

endmodule
